### hw/rtl/rgb_luma_laplacian_3x3_filter_defines.svh
// Assertion macros shared by the luma Laplacian filter modules.
`ifndef RGB_LUMA_LAPLACIAN_3X3_FILTER_DEFINES_SVH
`define RGB_LUMA_LAPLACIAN_3X3_FILTER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define RLLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define RLLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rllf_pkg.sv
// Types and constants of the luma Laplacian filter.
package rllf_pkg;

  localparam int MAX_LINE_WIDTH   = 64;
  localparam int MAX_FRAME_HEIGHT = 2048;
  localparam int MIN_SIZE         = 3;

  localparam int COL_W        = $clog2(MAX_LINE_WIDTH);
  localparam int ROW_W        = $clog2(MAX_FRAME_HEIGHT);
  localparam int WIDTH_REG_W  = 7;
  localparam int HEIGHT_REG_W = 12;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(64);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(48);

  // Register index, taken from paddr bit 2.
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  localparam int LUMA_W     = 8;
  localparam int LUMA_PROD_W = 16;
  localparam int LUMA_SHIFT = 8;
  localparam logic [LUMA_W-1:0] LUMA_KR = 8'd77;
  localparam logic [LUMA_W-1:0] LUMA_KG = 8'd150;
  localparam logic [LUMA_W-1:0] LUMA_KB = 8'd29;

  localparam int SUM_W = 11;
  localparam logic [LUMA_W-1:0] PIX_MAX = 8'hff;

  localparam int RAM_W = 2 * LUMA_W;

  localparam int RESULTS_MAX = 2;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  width;
    logic [HEIGHT_REG_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  orow;
    logic [LUMA_W-1:0] luma;
    logic              emit_first;
    logic              emit_edge;
    logic              interior;
  } work_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [LUMA_W-1:0] value;
    logic              last;
  } result_t;

  typedef struct packed {
    logic    push_first;
    logic    push_second;
    result_t first;
    result_t second;
  } q_write_t;

endpackage

### hw/rtl/rllf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rllf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

### hw/rtl/rllf_front.sv
// Front end: position counters, luma conversion, line store read and credit check.
`include "rgb_luma_laplacian_3x3_filter_defines.svh"
module rllf_front import rllf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              push,
  input  logic [23:0]       pixel,
  output logic              full,
  input  logic [QCNT_W-1:0] q_count,
  output logic              rd_en,
  output logic [COL_W-1:0]  rd_addr,
  output logic              work_valid,
  output work_t             work
);

  logic [COL_W-1:0]        col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]        row_cnt_r, row_cnt_nxt;
  logic                    work_valid_r;
  work_t                   work_r, work_nxt;
  logic [WIDTH_REG_W-1:0]  eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;
  logic [COL_W-1:0]        w_m1, c;
  logic [ROW_W-1:0]        h_m1, r, orow;
  logic [LUMA_PROD_W-1:0]  luma_sum;
  logic                    accept;

  always_comb begin
    if (cfg.width < WIDTH_REG_W'(MIN_SIZE)) begin
      eff_w = WIDTH_REG_W'(MIN_SIZE);
    end else if (cfg.width > WIDTH_REG_W'(MAX_LINE_WIDTH)) begin
      eff_w = WIDTH_REG_W'(MAX_LINE_WIDTH);
    end else begin
      eff_w = cfg.width;
    end
    if (cfg.height < HEIGHT_REG_W'(MIN_SIZE)) begin
      eff_h = HEIGHT_REG_W'(MIN_SIZE);
    end else if (cfg.height > HEIGHT_REG_W'(MAX_FRAME_HEIGHT)) begin
      eff_h = HEIGHT_REG_W'(MAX_FRAME_HEIGHT);
    end else begin
      eff_h = cfg.height;
    end
  end

  assign w_m1 = COL_W'(eff_w - WIDTH_REG_W'(1));
  assign h_m1 = ROW_W'(eff_h - HEIGHT_REG_W'(1));

  // Treat a counter beyond a shrunk frame as the last column or row.
  assign c = (WIDTH_REG_W'(col_cnt_r) < eff_w) ? col_cnt_r : w_m1;
  assign r = (HEIGHT_REG_W'(row_cnt_r) < eff_h) ? row_cnt_r : h_m1;

  always_comb begin
    if (r == '0) begin
      orow = '0;
    end else if (r == ROW_W'(1)) begin
      orow = h_m1;
    end else begin
      orow = r - ROW_W'(1);
    end
  end

  assign luma_sum = LUMA_PROD_W'(LUMA_KR) * LUMA_PROD_W'(pixel[23:16])
                  + LUMA_PROD_W'(LUMA_KG) * LUMA_PROD_W'(pixel[15:8])
                  + LUMA_PROD_W'(LUMA_KB) * LUMA_PROD_W'(pixel[7:0]);

  // Admit an item only when the queue has room for its results and those in flight.
  assign full   = (int'(q_count) + (work_valid_r ? RESULTS_MAX : 0) + RESULTS_MAX)
                  > QUEUE_DEPTH;
  assign accept = push && !full;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (accept) begin
      if (c >= w_m1) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (r >= h_m1) ? '0 : r + ROW_W'(1);
      end else begin
        col_cnt_nxt = c + COL_W'(1);
        row_cnt_nxt = r;
      end
    end
  end

  always_comb begin
    work_nxt.col        = c;
    work_nxt.orow       = orow;
    work_nxt.luma       = LUMA_W'(luma_sum >> LUMA_SHIFT);
    work_nxt.emit_first = (c >= COL_W'(1));
    work_nxt.emit_edge  = (c == w_m1);
    work_nxt.interior   = (r >= ROW_W'(2)) && (c >= COL_W'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r    <= '0;
      row_cnt_r    <= '0;
      work_valid_r <= 1'b0;
    end else begin
      col_cnt_r    <= col_cnt_nxt;
      row_cnt_r    <= row_cnt_nxt;
      work_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work_r <= work_nxt;
    end
  end

  assign rd_en      = accept;
  assign rd_addr    = c;
  assign work_valid = work_valid_r;
  assign work       = work_r;

  `RLLF_ASSERT_NOW(a_room_in_flight, work_valid_r, (int'(q_count) + RESULTS_MAX) <= QUEUE_DEPTH, "queue lacks room for item in flight")

endmodule

### hw/rtl/rllf_back.sv
// Back end: window columns, Laplacian sum, clamp and result generation.
module rllf_back import rllf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             work_valid,
  input  work_t            work,
  input  logic [RAM_W-1:0] rd_data,
  output logic             wr_en,
  output logic [COL_W-1:0] wr_addr,
  output logic [RAM_W-1:0] wr_data,
  output q_write_t         q_wr
);

  logic [LUMA_W-1:0] win_r [6];
  logic [LUMA_W-1:0] win_nxt [6];
  logic [LUMA_W-1:0] top, mid, bot, value;
  logic [SUM_W-1:0]  pos, neg, diff;

  assign top = rd_data[RAM_W-1:LUMA_W];
  assign mid = rd_data[LUMA_W-1:0];
  assign bot = work.luma;

  assign pos = {win_r[4], 3'b000};
  assign neg = SUM_W'(win_r[0]) + SUM_W'(win_r[1]) + SUM_W'(win_r[2])
             + SUM_W'(win_r[3]) + SUM_W'(win_r[5])
             + SUM_W'(top) + SUM_W'(mid) + SUM_W'(bot);
  assign diff = pos - neg;

  always_comb begin
    if (!work.interior || neg >= pos) begin
      value = '0;
    end else if (diff > SUM_W'(PIX_MAX)) begin
      value = PIX_MAX;
    end else begin
      value = LUMA_W'(diff);
    end
  end

  always_comb begin
    win_nxt[0] = win_r[3];
    win_nxt[1] = win_r[4];
    win_nxt[2] = win_r[5];
    win_nxt[3] = top;
    win_nxt[4] = mid;
    win_nxt[5] = bot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (work_valid) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // Shift the line store down by one row at this column.
  assign wr_en   = work_valid;
  assign wr_addr = work.col;
  assign wr_data = {mid, bot};

  always_comb begin
    q_wr.push_first   = work_valid && work.emit_first;
    q_wr.push_second  = work_valid && work.emit_edge;
    q_wr.first.col    = work.col - COL_W'(1);
    q_wr.first.row    = work.orow;
    q_wr.first.value  = value;
    q_wr.first.last   = !work.emit_edge;
    q_wr.second.col   = work.col;
    q_wr.second.row   = work.orow;
    q_wr.second.value = '0;
    q_wr.second.last  = 1'b1;
  end

endmodule

### hw/rtl/rllf_queue.sv
// Result queue: takes up to two results per cycle, hands out one.
`include "rgb_luma_laplacian_3x3_filter_defines.svh"
module rllf_queue import rllf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  q_write_t          q_wr,
  input  logic              pop,
  output logic              empty,
  output result_t           head,
  output logic [QCNT_W-1:0] count
);

  result_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [1:0]        wr_n;
  logic              pop_ok;

  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);
  assign wr_n      = 2'(q_wr.push_first) + 2'(q_wr.push_second);
  assign pop_ok    = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(wr_n);
    rd_ptr_nxt = pop_ok ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(wr_n) - QCNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push_first) begin
      mem_r[wr_ptr_r] <= q_wr.first;
    end
    if (q_wr.push_second) begin
      mem_r[wr_ptr_p1] <= q_wr.second;
    end
  end

  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

  `RLLF_ASSERT_NOW(a_count_bound, 1'b1, int'(count_r) <= QUEUE_DEPTH, "result queue overfilled")
  `RLLF_ASSERT_NOW(a_edge_follows_first, q_wr.push_second, q_wr.push_first, "edge result without its column result")
  `RLLF_ASSERT_NEXT(a_pop_drains, pop_ok && (wr_n == 2'd0), count_r == $past(count_r) - QCNT_W'(1), "transfer out did not drain queue")

endmodule

### hw/rtl/rgb_luma_laplacian_3x3_filter.sv
// Top level of the RGB luma 3x3 Laplacian edge filter.
// A transferred pixel is registered with its line-store read; its results then enter the queue that drives out_.
// Throughput: one pixel per cycle while full is low; a line of W pixels yields W results (none for
// column 0, two for the last column), so one result transfer per cycle keeps pace with the input.
// Reset clears the position counters, the window columns and the queue, and restores width 64
// and height 48; the luma line store is not cleared, so no clearing pass is needed.
module rgb_luma_laplacian_3x3_filter import rllf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel
  input  logic                push,
  output logic                full,
  input  logic [23:0]         in_rgb_pixel,
  // Result channel
  output logic                empty,
  input  logic                pop,
  output logic [COL_W-1:0]    out_col,
  output logic [ROW_W-1:0]    out_row,
  output logic [23:0]         out_filtered_pixel,
  output logic                out_last_of_run,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [WIDTH_REG_W-1:0]  width_r, width_nxt;
  logic [HEIGHT_REG_W-1:0] height_r, height_nxt;
  logic                    cfg_wr;
  logic                    reg_idx;
  cfg_t                    cfg;

  logic              rd_en, wr_en, work_valid;
  logic [COL_W-1:0]  rd_addr, wr_addr;
  logic [RAM_W-1:0]  rd_data, wr_data;
  work_t             work;
  q_write_t          q_wr;
  result_t           head;
  logic [QCNT_W-1:0] q_count;

  // Configuration registers: always ready, written on the access phase of a transfer.
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_IDX_WIDTH:  width_nxt  = pwdata[WIDTH_REG_W-1:0];
        REG_IDX_HEIGHT: height_nxt = pwdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IDX_WIDTH:  prdata = DATA_W'(width_r);
      REG_IDX_HEIGHT: prdata = DATA_W'(height_r);
      default:        prdata = '0;
    endcase
  end

  assign cfg.width  = width_r;
  assign cfg.height = height_r;

  // Front: count positions, convert to luma, read the two rows above and
  // hold the pixel back whenever the queue could not take its results.
  rllf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .push       (push),
    .pixel      (in_rgb_pixel),
    .full       (full),
    .q_count    (q_count),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .work_valid (work_valid),
    .work       (work)
  );

  // Line store: one entry per column holds {two rows back, one row back}.
  rllf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Back: advance the window, evaluate the kernel and push results.
  rllf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .work_valid (work_valid),
    .work       (work),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .q_wr       (q_wr)
  );

  // Result queue decouples the back end from the consumer.
  rllf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (pop),
    .empty (empty),
    .head  (head),
    .count (q_count)
  );

  // Replicate the filtered luma into R, G and B.
  assign out_col            = head.col;
  assign out_row            = head.row;
  assign out_filtered_pixel = {head.value, head.value, head.value};
  assign out_last_of_run    = head.last;

endmodule

### verif/tb_rgb_luma_laplacian_3x3_filter.sv
// Self-checking testbench for the luma Laplacian filter, with its own predictor of each frame.
module tb_rgb_luma_laplacian_3x3_filter import rllf_pkg::*; ();

  // Give up when no transfer of any kind happens for this many cycles.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to let pass once nothing is expected: column 0 makes no result.
  localparam int SETTLE_CYCLES  = 4;

  // Two 3x3 frames: a bright centre on dark neighbours (clamps high), then a
  // dark centre on white neighbours (clamps low). Corners use one channel each.
  localparam logic [23:0] PROBE_PIXELS [18] = '{
    24'hff0000, 24'h00ff00, 24'h0000ff,
    24'h000000, 24'hffffff, 24'h000000,
    24'h0000ff, 24'h00ff00, 24'hff0000,
    24'hffffff, 24'hffffff, 24'hffffff,
    24'hffffff, 24'h000000, 24'hffffff,
    24'hffffff, 24'hffffff, 24'hffffff
  };

  // Predicts the edge map of each accepted pixel and checks the results against it.
  class luma_edge_scoreboard;
    typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [23:0]      pixel;
      logic             last;
    } edge_result_t;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [7:0]              upper_row [MAX_LINE_WIDTH];
    logic [7:0]              middle_row [MAX_LINE_WIDTH];
    logic [7:0]              window [6];
    logic [COL_W-1:0]        col_cnt;
    logic [ROW_W-1:0]        row_cnt;
    edge_result_t            pending_edges [$];
    int                      mismatches;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col_cnt    = '0;
      row_cnt    = '0;
      mismatches = 0;
    endfunction

    function int eff_width();
      if (width_reg < MIN_SIZE) return MIN_SIZE;
      if (width_reg > MAX_LINE_WIDTH) return MAX_LINE_WIDTH;
      return width_reg;
    endfunction

    function int eff_height();
      if (height_reg < MIN_SIZE) return MIN_SIZE;
      if (height_reg > MAX_FRAME_HEIGHT) return MAX_FRAME_HEIGHT;
      return height_reg;
    endfunction

    function void set_reg(logic idx, logic [DATA_W-1:0] value);
      if (idx == REG_IDX_WIDTH) width_reg = value[WIDTH_REG_W-1:0];
      else height_reg = value[HEIGHT_REG_W-1:0];
    endfunction

    function bit at_frame_start();
      return col_cnt == 0 && row_cnt == 0;
    endfunction

    function int pending();
      return pending_edges.size();
    endfunction

    // Counters past a shrunk size count as the last column or row.
    function int pixels_to_frame_end();
      int w, h, c, r;
      w = eff_width();
      h = eff_height();
      c = (col_cnt < w) ? col_cnt : w - 1;
      r = (row_cnt < h) ? row_cnt : h - 1;
      return (h - 1 - r) * w + (w - c);
    endfunction

    function void queue_edge(int col, int row, logic [7:0] val, logic last);
      pending_edges.push_back('{COL_W'(col), ROW_W'(row), {val, val, val}, last});
    endfunction

    function void note_pixel(logic [23:0] rgb);
      int         w, h, c, r, top, mid, bot, orow, acc;
      logic [7:0] val;
      w    = eff_width();
      h    = eff_height();
      c    = (col_cnt < w) ? col_cnt : w - 1;
      r    = (row_cnt < h) ? row_cnt : h - 1;
      top  = upper_row[c];
      mid  = middle_row[c];
      bot  = (77 * rgb[23:16] + 150 * rgb[15:8] + 29 * rgb[7:0]) >> 8;
      // Row 0 and the last row are produced early, as all-zero border rows.
      orow = (r == 0) ? 0 : ((r == 1) ? h - 1 : r - 1);
      if (c >= 1) begin
        val = '0;
        if (r >= 2 && c >= 2) begin
          acc = 8 * int'(window[4]) - top - mid - bot;
          foreach (window[k]) if (k != 4) acc -= int'(window[k]);
          if (acc < 0) acc = 0;
          if (acc > 255) acc = 255;
          val = acc[7:0];
        end
        queue_edge(c - 1, orow, val, c != w - 1);
      end
      if (c == w - 1) queue_edge(w - 1, orow, 8'h00, 1'b1);
      window[0]     = window[3];
      window[1]     = window[4];
      window[2]     = window[5];
      window[3]     = top[7:0];
      window[4]     = mid[7:0];
      window[5]     = bot[7:0];
      upper_row[c]  = mid[7:0];
      middle_row[c] = bot[7:0];
      if (c >= w - 1) begin
        col_cnt = '0;
        row_cnt = (r >= h - 1) ? '0 : ROW_W'(r + 1);
      end else begin
        col_cnt = COL_W'(c + 1);
        row_cnt = ROW_W'(r);
      end
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_edge(logic [COL_W-1:0] col, logic [ROW_W-1:0] row, logic [23:0] pixel,
                    logic last);
      edge_result_t exp_edge;
      string        diffs;
      if (pending_edges.size() == 0) begin
        report($sformatf("result col %0d row %0d with nothing expected", col, row));
        return;
      end
      exp_edge = pending_edges.pop_front();
      diffs    = "";
      if (col !== exp_edge.col)
        diffs = {diffs, $sformatf(" col %0d/%0d", exp_edge.col, col)};
      if (row !== exp_edge.row)
        diffs = {diffs, $sformatf(" row %0d/%0d", exp_edge.row, row)};
      if (pixel !== exp_edge.pixel)
        diffs = {diffs, $sformatf(" pixel %06h/%06h", exp_edge.pixel, pixel)};
      if (last !== exp_edge.last)
        diffs = {diffs, $sformatf(" last %0b/%0b", exp_edge.last, last)};
      if (diffs != "")
        report($sformatf("at col %0d row %0d (exp/got):%s", exp_edge.col, exp_edge.row,
                         diffs));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                push;
  logic                full;
  logic [23:0]         in_rgb_pixel;
  logic                empty;
  logic                pop;
  logic [COL_W-1:0]    out_col;
  logic [ROW_W-1:0]    out_row;
  logic [23:0]         out_filtered_pixel;
  logic                out_last_of_run;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  luma_edge_scoreboard sb;

  int sender_gap_pct     = 0;
  int receiver_stall_pct = 0;
  int rx_hold_cycles     = 0;
  int pixels_sent        = 0;
  int quiet_cycles       = 0;

  rgb_luma_laplacian_3x3_filter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_rgb_pixel       (in_rgb_pixel),
    .empty              (empty),
    .pop                (pop),
    .out_col            (out_col),
    .out_row            (out_row),
    .out_filtered_pixel (out_filtered_pixel),
    .out_last_of_run    (out_last_of_run),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #6 clk = ~clk;

  // Observe every transfer at the rising edge. Values read here are the ones
  // that held just before the edge, so no check depends on process order.
  // Feed accepted pixels to the predictor, check accepted results, and keep
  // the watchdog: any transfer on either channel or the register port
  // restarts its count.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) sb.note_pixel(in_rgb_pixel);
      if (pop && !empty)
        sb.check_edge(out_col, out_row, out_filtered_pixel, out_last_of_run);
      if ((push && !full) || (pop && !empty) || (psel && penable)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result side: stall at random, or hold pop low for a counted stretch when
  // the stimulus asks for back-pressure. Change pop only at the falling edge.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        pop = 1'b0;
        rx_hold_cycles--;
      end else begin
        pop = ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Offer one pixel, idling beforehand at random. Keep push high afterwards
  // so that back-to-back pixels transfer on consecutive edges.
  task automatic send_pixel(input logic [23:0] rgb);
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push         = 1'b1;
    in_rgb_pixel = rgb;
    do @(posedge clk); while (full);
    pixels_sent++;
  endtask

  // Drop push and hold off until every expected result has come out, then wait
  // a settle time so a trailing column-0 pixel (which makes no result) clears.
  task automatic wait_drained();
    @(negedge clk);
    push = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then read it back in the very next transfer.
  task automatic program_reg(input logic idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] readback;
    logic [DATA_W-1:0] mask;
    mask = (idx == REG_IDX_WIDTH) ? DATA_W'((1 << WIDTH_REG_W) - 1)
                                  : DATA_W'((1 << HEIGHT_REG_W) - 1);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    sb.set_reg(idx, value);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback !== (value & mask))
      sb.report($sformatf("register %0d read %0h, wrote %0h", idx, readback, value));
  endtask

  // One burst of pixels under a fresh size setting. The width only grows at
  // the start of a frame, so every line-store entry read has been filled.
  // Other bursts stop mid-frame, so later shrinks leave the counters beyond
  // the new size.
  task automatic random_segment();
    int         w_val, h_val, count, sel, level, cap;
    bit         grey;
    logic [7:0] base;
    sel = $urandom_range(0, 19);
    if (sel == 0) w_val = $urandom_range(0, 2);
    else if (sel == 1) w_val = MAX_LINE_WIDTH;
    else if (sel == 2) w_val = $urandom_range(MAX_LINE_WIDTH + 1, 127);
    else w_val = $urandom_range(MIN_SIZE, 10);
    if (!sb.at_frame_start() && w_val > sb.eff_width())
      w_val = $urandom_range(MIN_SIZE, sb.eff_width());
    sel = $urandom_range(0, 19);
    if (sel == 0) h_val = $urandom_range(0, 2);
    else if (sel == 1) h_val = MAX_FRAME_HEIGHT;
    else if (sel == 2) h_val = $urandom_range(MAX_FRAME_HEIGHT + 1, 4095);
    else h_val = $urandom_range(MIN_SIZE, 6);
    program_reg(REG_IDX_WIDTH, w_val);
    program_reg(REG_IDX_HEIGHT, h_val);
    // Grey frames with mild noise give mid-range filter values; full-range
    // colour mostly saturates.
    grey  = $urandom_range(1);
    base  = $urandom_range(0, 255);
    cap   = sb.pixels_to_frame_end();
    count = ($urandom_range(1) && cap <= 80) ? cap : $urandom_range(1, 40);
    repeat (count) begin
      if (grey) begin
        level = base + $urandom_range(0, 24);
        if (level > 255) level = 255;
        send_pixel({3{level[7:0]}});
      end else begin
        send_pixel($urandom_range(0, 24'hffffff));
      end
    end
    wait_drained();
  endtask

  initial begin
    int target;
    sb           = new();
    rst_n        = 1'b0;
    push         = 1'b0;
    in_rgb_pixel = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Smallest frame: both clamp directions and each colour channel alone.
    program_reg(REG_IDX_WIDTH, MIN_SIZE);
    program_reg(REG_IDX_HEIGHT, MIN_SIZE);
    foreach (PROBE_PIXELS[i]) send_pixel(PROBE_PIXELS[i]);
    wait_drained();

    // Widest line, with the result side held off long enough for the block to
    // fill and stall its input while pixels keep being offered.
    program_reg(REG_IDX_WIDTH, MAX_LINE_WIDTH);
    program_reg(REG_IDX_HEIGHT, MIN_SIZE);
    rx_hold_cycles = 300;
    repeat (MAX_LINE_WIDTH * MIN_SIZE) send_pixel($urandom_range(0, 24'hffffff));
    wait_drained();

    // Tallest frame: the bottom border row comes out during input row 1.
    program_reg(REG_IDX_WIDTH, MIN_SIZE);
    program_reg(REG_IDX_HEIGHT, MAX_FRAME_HEIGHT);
    repeat (8) send_pixel($urandom_range(0, 24'hffffff));
    wait_drained();

    // Random bursts under each idling pattern in turn.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_gap_pct = 77; receiver_stall_pct = 0;  end
        2: begin sender_gap_pct = 0;  receiver_stall_pct = 77; end
        default: begin sender_gap_pct = 26; receiver_stall_pct = 26; end
      endcase
      target = pixels_sent + 130;
      while (pixels_sent < target) random_segment();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
